@@ rtl/mhtq_pkg.sv @@
// Shared types and codes for the min-heap timer queue.
// No dependencies; the ALU, the top level and the testbench import this package.
package mhtq_pkg;

  localparam int TIME_W     = 63;
  localparam int FIRE_LIMIT = 32;

  localparam logic [1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [1:0] ACT_CANCEL   = 2'd1;
  localparam logic [1:0] ACT_UPDATE   = 2'd2;

  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] now;
    logic [31:0]       delay;
    logic [15:0]       timer_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic [5:0]  fired_count;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UP_RD, ST_UP_CK, ST_DN_RDL, ST_DN_RDR, ST_DN_SEL, ST_DN_CK,
    ST_RM, ST_RM_LD, ST_SCAN_RD, ST_SCAN_CK, ST_UPD_RD, ST_UPD_CK, ST_FIN
  } st_t;

endpackage

@@ rtl/mhtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mhtq_alu.sv @@
// Shared time unit: saturating add and less-than compare on 63-bit times.
// Depends on mhtq_pkg.
module mhtq_alu (
  input  logic [mhtq_pkg::TIME_W-1:0] a,
  input  logic [mhtq_pkg::TIME_W-1:0] b,
  output logic                        lt,
  output logic [mhtq_pkg::TIME_W-1:0] sum_sat
);
  import mhtq_pkg::*;
  logic [TIME_W:0] sum;

  assign sum     = {1'b0, a} + {1'b0, b};
  assign sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign lt      = a < b;
endmodule

@@ rtl/min_heap_timer_queue.sv @@
// Top level of the min-heap timer queue: sequencer, heap RAM, shared time unit.
// Depends on mhtq_pkg, mhtq_ram and mhtq_alu.
//
//   channel  | ports                  | transfer
//   ---------+------------------------+----------------------------------
//   input    | start, busy, in_item   | start high while busy low
//   result   | out_strobe, out_item   | one cycle per result, no stall
//
// Schedule: climbs the new entry up the heap, one parent read and compare per level.
// Cancel: scans the slots for the id, then removes the match with a sift.
// Update: fires and removes the root while it is due; at most 32 fire per call.
// All heap traffic goes through one RAM port pair and one compare unit.
// Reset clears size and id counter; no RAM clear is needed.
module min_heap_timer_queue #(
  parameter int CAPACITY = 32,
  parameter int ID_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mhtq_pkg::in_t  in_item,
  output logic           out_strobe,
  output mhtq_pkg::out_t out_item
);
  import mhtq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = TIME_W + ID_BITS;

  st_t st_r, st_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_BITS-1:0] tid_r, tid_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt, start_r, start_nxt, c_r, c_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt, n_r, n_nxt;
  logic [ID_BITS-1:0] idc_r, idc_nxt, rid_r, rid_nxt;
  logic [TIME_W-1:0] e_exp_r, e_exp_nxt, l_exp_r, l_exp_nxt;
  logic [ID_BITS-1:0] e_id_r, e_id_nxt, l_id_r, l_id_nxt;
  logic [5:0]        fired_r, fired_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_r, out_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ENT_W-1:0]  wdata, rd_q;
  logic [TIME_W-1:0] rd_exp, alu_a, alu_b, alu_sum;
  logic [ID_BITS-1:0] rd_id;
  logic              alu_lt;
  logic [CNT_W:0]    lchild, rchild;
  logic [CNT_W-1:0]  parent, pos_m1;
  logic              accept;

  assign rd_exp = rd_q[ENT_W-1:ID_BITS];
  assign rd_id  = rd_q[ID_BITS-1:0];
  assign lchild = {pos_r, 1'b1};
  assign rchild = lchild + 1'b1;
  assign pos_m1 = pos_r - 1'b1;
  assign parent = pos_m1 >> 1;
  assign accept = start && (st_r == ST_IDLE);
  assign busy   = (st_r != ST_IDLE);

  mhtq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_q)
  );

  mhtq_alu u_alu (.a(alu_a), .b(alu_b), .lt(alu_lt), .sum_sat(alu_sum));

  // Pick operands for the shared time unit.
  always_comb begin
    alu_a = l_exp_r;
    alu_b = e_exp_r;
    case (st_r)
      ST_IDLE: begin
        alu_a = in_item.now;
        alu_b = TIME_W'(in_item.delay);
      end
      ST_UP_CK: begin
        alu_a = e_exp_r;
        alu_b = rd_exp;
      end
      ST_DN_SEL: begin
        alu_a = l_exp_r;
        alu_b = rd_exp;
      end
      ST_UPD_CK: begin
        alu_a = now_r;
        alu_b = rd_exp;
      end
      default: begin
        alu_a = l_exp_r;
        alu_b = e_exp_r;
      end
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.action)
            ACT_SCHEDULE: st_nxt = (size_r >= CNT_W'(CAPACITY)) ? ST_IDLE : ST_UP_RD;
            ACT_CANCEL:   st_nxt = ST_SCAN_RD;
            ACT_UPDATE:   st_nxt = ST_UPD_RD;
            default:      st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UP_RD:  st_nxt = (pos_r == '0) ? ST_FIN : ST_UP_CK;
      ST_UP_CK:  st_nxt = alu_lt ? ST_UP_RD : ST_FIN;
      ST_DN_RDL: begin
        if (lchild >= {1'b0, n_r}) begin
          st_nxt = (pos_r != start_r) ? ST_FIN : ST_UP_RD;
        end else begin
          st_nxt = ST_DN_RDR;
        end
      end
      ST_DN_RDR: st_nxt = (rchild < {1'b0, n_r}) ? ST_DN_SEL : ST_DN_CK;
      ST_DN_SEL: st_nxt = ST_DN_CK;
      ST_DN_CK: begin
        if (alu_lt) begin
          st_nxt = ST_DN_RDL;
        end else begin
          st_nxt = (pos_r != start_r) ? ST_FIN : ST_UP_RD;
        end
      end
      ST_RM:      st_nxt = (pos_r == size_r - 1'b1) ? ST_FIN : ST_RM_LD;
      ST_RM_LD:   st_nxt = ST_DN_RDL;
      ST_SCAN_RD: st_nxt = (pos_r >= size_r) ? ST_IDLE : ST_SCAN_CK;
      ST_SCAN_CK: st_nxt = (rd_id == tid_r) ? ST_RM : ST_SCAN_RD;
      ST_UPD_RD: begin
        st_nxt = (size_r == '0 || fired_r == 6'(FIRE_LIMIT)) ? ST_IDLE : ST_UPD_CK;
      end
      ST_UPD_CK: st_nxt = alu_lt ? ST_IDLE : ST_RM;
      ST_FIN:    st_nxt = (op_r == ACT_UPDATE) ? ST_UPD_RD : ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and results.
  always_comb begin
    op_nxt = op_r;  now_nxt = now_r;  tid_nxt = tid_r;
    pos_nxt = pos_r;  start_nxt = start_r;  c_nxt = c_r;
    size_nxt = size_r;  n_nxt = n_r;  idc_nxt = idc_r;  rid_nxt = rid_r;
    e_exp_nxt = e_exp_r;  e_id_nxt = e_id_r;
    l_exp_nxt = l_exp_r;  l_id_nxt = l_id_r;
    fired_nxt = fired_r;
    out_strobe_nxt = 1'b0;
    out_nxt = out_r;
    we = 1'b0;
    waddr = pos_r[IDX_W-1:0];
    wdata = {e_exp_r, e_id_r};
    raddr = pos_r[IDX_W-1:0];
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = in_item.action;
          now_nxt = in_item.now;
          tid_nxt = ID_BITS'(32'(in_item.timer_id));
          fired_nxt = '0;
          pos_nxt = '0;
          case (in_item.action)
            ACT_SCHEDULE: begin
              if (size_r >= CNT_W'(CAPACITY)) begin
                out_strobe_nxt = 1'b1;
                out_nxt = '{KIND_REJECTED, 16'd0, 6'd0, 1'b1};
              end else begin
                idc_nxt = idc_r + 1'b1;
                rid_nxt = idc_r + 1'b1;
                e_exp_nxt = alu_sum;
                e_id_nxt = idc_r + 1'b1;
                pos_nxt = size_r;
                size_nxt = size_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_UP_RD: begin
        raddr = parent[IDX_W-1:0];
        if (pos_r == '0) begin
          we = 1'b1;
        end
      end
      ST_UP_CK: begin
        we = 1'b1;
        if (alu_lt) begin
          wdata = rd_q;
          pos_nxt = parent;
        end
      end
      ST_DN_RDL: begin
        raddr = lchild[IDX_W-1:0];
        if (lchild >= {1'b0, n_r}) begin
          we = 1'b1;
        end
      end
      ST_DN_RDR: begin
        raddr = rchild[IDX_W-1:0];
        l_exp_nxt = rd_exp;
        l_id_nxt = rd_id;
        c_nxt = lchild[CNT_W-1:0];
      end
      ST_DN_SEL: begin
        // Take the right child unless the left is strictly earlier.
        if (!alu_lt) begin
          l_exp_nxt = rd_exp;
          l_id_nxt = rd_id;
          c_nxt = rchild[CNT_W-1:0];
        end
      end
      ST_DN_CK: begin
        we = 1'b1;
        if (alu_lt) begin
          wdata = {l_exp_r, l_id_r};
          pos_nxt = c_r;
        end
      end
      ST_RM: begin
        n_nxt = size_r - 1'b1;
        size_nxt = size_r - 1'b1;
        raddr = n_nxt[IDX_W-1:0];
      end
      ST_RM_LD: begin
        e_exp_nxt = rd_exp;
        e_id_nxt = rd_id;
        start_nxt = pos_r;
      end
      ST_SCAN_RD: begin
        if (pos_r >= size_r) begin
          out_strobe_nxt = 1'b1;
          out_nxt = '{KIND_NOT_FOUND, 16'd0, 6'd0, 1'b1};
        end
      end
      ST_SCAN_CK: begin
        if (rd_id == tid_r) begin
          rid_nxt = rd_id;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      ST_UPD_RD: begin
        raddr = '0;
        if (size_r == '0 || fired_r == 6'(FIRE_LIMIT)) begin
          out_strobe_nxt = 1'b1;
          out_nxt = '{KIND_DONE, 16'd0, fired_r, 1'b1};
        end
      end
      ST_UPD_CK: begin
        out_strobe_nxt = 1'b1;
        if (alu_lt) begin
          out_nxt = '{KIND_DONE, 16'd0, fired_r, 1'b1};
        end else begin
          out_nxt = '{KIND_FIRED, 16'(32'(rd_id)), 6'd0, 1'b0};
          fired_nxt = fired_r + 1'b1;
          pos_nxt = '0;
        end
      end
      ST_FIN: begin
        if (op_r != ACT_UPDATE) begin
          out_strobe_nxt = 1'b1;
          out_nxt = '{(op_r == ACT_SCHEDULE) ? KIND_SCHEDULED : KIND_CANCELLED,
                      16'(32'(rid_r)), 6'd0, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      size_r <= '0;
      idc_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      size_r <= size_nxt;
      idc_r <= idc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  now_r <= now_nxt;  tid_r <= tid_nxt;
    pos_r <= pos_nxt;  start_r <= start_nxt;  c_r <= c_nxt;
    n_r <= n_nxt;  rid_r <= rid_nxt;
    e_exp_r <= e_exp_nxt;  e_id_r <= e_id_nxt;
    l_exp_r <= l_exp_nxt;  l_id_r <= l_id_nxt;
    fired_r <= fired_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;
endmodule

@@ test/min_heap_timer_queue_tb.sv @@
// Self-checking testbench for min_heap_timer_queue: table-driven directed items
// and random traffic, all checked against a heap predictor.
// Depends on mhtq_pkg and the min_heap_timer_queue RTL.
module min_heap_timer_queue_tb;
  import mhtq_pkg::*;

  localparam int                CAP      = 32;
  localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
  localparam int                STALL_MAX = 6000;
  localparam logic [1:0]        ACT_NONE  = 2'd3;
  localparam logic [2:0]        KIND_NONE = 3'd7;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_strobe;
  out_t out_item;

  min_heap_timer_queue #(.CAPACITY(CAP), .ID_BITS(16)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Predictor state: a private copy of the heap, its size and the id counter.
  logic [TIME_W-1:0] heap_exp[CAP];
  logic [15:0]       heap_tid[CAP];
  int                heap_cnt;
  logic [15:0]       last_id;

  out_t              pending_results[$];
  int                fail_count;
  int                accept_count;
  int                result_count;
  int                idle_pct;
  logic [TIME_W-1:0] clock_now;

  function automatic void queue_result(out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [TIME_W-1:0] e;
    logic [15:0]       d;
    e = heap_exp[a]; d = heap_tid[a];
    heap_exp[a] = heap_exp[b]; heap_tid[a] = heap_tid[b];
    heap_exp[b] = e; heap_tid[b] = d;
  endfunction

  // Ties go to the right child; only a strictly smaller child moves up.
  function automatic bit sink(int from, int n);
    int i;
    int l;
    int c;
    i = from;
    forever begin
      l = 2 * i + 1;
      if (l >= n) break;
      c = l;
      if (l + 1 < n && !(heap_exp[l] < heap_exp[l + 1])) c = l + 1;
      if (!(heap_exp[c] < heap_exp[i])) break;
      swap_entries(i, c);
      i = c;
    end
    return i > from;
  endfunction

  function automatic void rise(int j);
    int p;
    while (j > 0) begin
      p = (j - 1) / 2;
      if (!(heap_exp[j] < heap_exp[p])) break;
      swap_entries(p, j);
      j = p;
    end
  endfunction

  function automatic void drop_slot(int i);
    int n;
    n = heap_cnt - 1;
    if (i != n) begin
      swap_entries(i, n);
      if (!sink(i, n)) rise(i);
    end
    heap_cnt = n;
  endfunction

  function automatic out_t make_result(logic [2:0] k, logic [15:0] id, logic [5:0] cnt,
                                       logic lst);
    out_t r;
    r.kind = k; r.result_id = id; r.fired_count = cnt; r.last = lst;
    return r;
  endfunction

  // Advance the predictor by one accepted transaction; queue its results and
  // hand back the first one (KIND_NONE marks "no result").
  function automatic out_t predict_queue_step(in_t it);
    logic [TIME_W:0] sum;
    int              fired;
    int              i;
    out_t            first;
    first = make_result(KIND_NONE, '0, '0, 1'b0);
    case (it.action)
      ACT_SCHEDULE: begin
        if (heap_cnt >= CAP) begin
          first = make_result(KIND_REJECTED, '0, '0, 1'b1);
        end else begin
          sum = {1'b0, it.now} + it.delay;
          last_id = last_id + 16'd1;
          heap_exp[heap_cnt] = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
          heap_tid[heap_cnt] = last_id;
          heap_cnt++;
          rise(heap_cnt - 1);
          first = make_result(KIND_SCHEDULED, last_id, '0, 1'b1);
        end
        queue_result(first);
      end
      ACT_CANCEL: begin
        first = make_result(KIND_NOT_FOUND, '0, '0, 1'b1);
        for (i = 0; i < heap_cnt; i++) begin
          if (heap_tid[i] == it.timer_id) begin
            first = make_result(KIND_CANCELLED, heap_tid[i], '0, 1'b1);
            drop_slot(i);
            break;
          end
        end
        queue_result(first);
      end
      ACT_UPDATE: begin
        fired = 0;
        while (heap_cnt > 0 && fired < FIRE_LIMIT && !(it.now < heap_exp[0])) begin
          queue_result(make_result(KIND_FIRED, heap_tid[0], '0, 1'b0));
          drop_slot(0);
          fired++;
        end
        queue_result(make_result(KIND_DONE, '0, 6'(fired), 1'b1));
        first = pending_results[pending_results.size() - 1 - fired];
      end
      default: ;
    endcase
    return first;
  endfunction

  // Hold start high until the block takes the transaction, then update the predictor.
  task automatic issue(input in_t it, output out_t first);
    @(negedge clk);
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    accept_count++;
    first = predict_queue_step(it);
  endtask

  task automatic issue_item(input in_t it);
    out_t ignored;
    int   gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    issue(it, ignored);
  endtask

  function automatic in_t pack_item(logic [1:0] a, logic [TIME_W-1:0] t, logic [31:0] d,
                                    logic [15:0] id);
    in_t it;
    it.action = a; it.now = t; it.delay = d; it.timer_id = id;
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] wide_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic in_t random_item();
    int                r;
    logic [TIME_W-1:0] t;
    logic [31:0]       d;
    logic [15:0]       id;
    clock_now = clock_now + TIME_W'($urandom_range(0, 40));
    t  = ($urandom_range(99) < 6) ? wide_time() : clock_now;
    d  = ($urandom_range(99) < 20) ? 32'($urandom) : 32'($urandom_range(0, 200));
    id = 16'($urandom);
    r  = $urandom_range(99);
    if (r < 45) return pack_item(ACT_SCHEDULE, t, d, id);
    if (r < 70) begin
      if (heap_cnt > 0 && $urandom_range(99) < 80) id = heap_tid[$urandom_range(heap_cnt - 1)];
      return pack_item(ACT_CANCEL, t, d, id);
    end
    if (r < 95) begin
      if ($urandom_range(99) < 3) t = TIME_TOP;
      return pack_item(ACT_UPDATE, t, d, id);
    end
    return pack_item(ACT_NONE, wide_time(), 32'($urandom), id);
  endfunction

  // Fill past capacity to force rejects, then drain everything in one update.
  task automatic fill_and_drain();
    repeat (36) issue_item(pack_item(ACT_SCHEDULE, wide_time(), 32'($urandom), '0));
    issue_item(pack_item(ACT_UPDATE, TIME_TOP, '0, '0));
  endtask

  task automatic random_phase(input int pct, input int count);
    idle_pct = pct;
    fill_and_drain();
    repeat (count) issue_item(random_item());
  endtask

  // Directed stimulus table: expectations typed in only where obvious.
  typedef struct {
    in_t  item;
    bit   checked;
    out_t first;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void add_row(logic [1:0] a, logic [TIME_W-1:0] t, logic [31:0] d,
                                  logic [15:0] id, bit chk, logic [2:0] k,
                                  logic [15:0] rid, logic [5:0] cnt);
    stim_row_t row;
    row.item    = pack_item(a, t, d, id);
    row.checked = chk;
    row.first   = make_result(k, rid, cnt, 1'b1);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Check every result against the oldest outstanding expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d id %0d", out_item.kind,
               out_item.result_id);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          fail_count++;
        end
        if (out_item.result_id !== want.result_id) begin
          $error("result_id: expected %0d, got %0d", want.result_id, out_item.result_id);
          fail_count++;
        end
        if (out_item.fired_count !== want.fired_count) begin
          $error("fired_count: expected %0d, got %0d", want.fired_count,
                 out_item.fired_count);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    int seen_acc;
    int seen_res;
    int quiet;
    if (accept_count != seen_acc || result_count != seen_res) begin
      quiet = 0;
    end else if (rst_n && ++quiet >= STALL_MAX) begin
      $display("min_heap_timer_queue test failed");
      $finish;
    end
    seen_acc = accept_count;
    seen_res = result_count;
  end

  initial begin
    out_t        got;
    int          n;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    fail_count = 0; accept_count = 0; result_count = 0; idle_pct = 0;
    heap_cnt = 0; last_id = '0; clock_now = '0;

    // Directed part: empty update, unknown id, ignored action, saturation, ties.
    add_row(ACT_UPDATE,   '0,       '0,      '0,    1, KIND_DONE,      '0,    '0);
    add_row(ACT_CANCEL,   '0,       '0,      16'd0, 1, KIND_NOT_FOUND, '0,    '0);
    add_row(ACT_NONE,     TIME_TOP, '1,      '1,    0, '0,             '0,    '0);
    add_row(ACT_SCHEDULE, '0,       '0,      '0,    1, KIND_SCHEDULED, 16'd1, '0);
    add_row(ACT_SCHEDULE, TIME_TOP, '1,      '1,    1, KIND_SCHEDULED, 16'd2, '0);
    add_row(ACT_SCHEDULE, '0,       '1,      '0,    1, KIND_SCHEDULED, 16'd3, '0);
    add_row(ACT_SCHEDULE, 63'd10,   32'd5,   '0,    1, KIND_SCHEDULED, 16'd4, '0);
    add_row(ACT_CANCEL,   '0,       '0,      16'd3, 1, KIND_CANCELLED, 16'd3, '0);
    add_row(ACT_CANCEL,   '0,       '0,      16'd3, 1, KIND_NOT_FOUND, '0,    '0);
    add_row(ACT_CANCEL,   '0,       '0,      '1,    1, KIND_NOT_FOUND, '0,    '0);
    add_row(ACT_UPDATE,   63'd15,   '0,      '0,    0, '0,             '0,    '0);
    add_row(ACT_UPDATE,   TIME_TOP, '0,      '0,    0, '0,             '0,    '0);
    add_row(ACT_SCHEDULE, 63'd100,  32'd7,   '0,    0, '0,             '0,    '0);
    add_row(ACT_SCHEDULE, 63'd100,  32'd7,   '0,    0, '0,             '0,    '0);
    add_row(ACT_SCHEDULE, 63'd90,   32'd17,  '0,    0, '0,             '0,    '0);
    add_row(ACT_SCHEDULE, 63'd100,  32'd3,   '0,    0, '0,             '0,    '0);
    add_row(ACT_CANCEL,   '0,       '0,      16'd5, 0, '0,             '0,    '0);
    add_row(ACT_UPDATE,   63'd106,  '0,      '0,    0, '0,             '0,    '0);
    add_row(ACT_UPDATE,   63'd107,  '0,      '0,    0, '0,             '0,    '0);
    add_row(ACT_UPDATE,   '0,       '0,      '0,    1, KIND_DONE,      '0,    '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      issue(stim_rows[i].item, got);
      if (stim_rows[i].checked && got !== stim_rows[i].first) begin
        $error("directed row %0d: expected %h, predicted %h", i, stim_rows[i].first, got);
        fail_count++;
      end
    end

    random_phase(27, 90);
    random_phase(69, 90);
    random_phase(0, 70);

    @(negedge clk);
    start = 1'b0;

    // Drain: wait for every expected result, then a short tail.
    n = 0;
    while (pending_results.size() != 0 && n < STALL_MAX) begin
      @(posedge clk);
      n++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("min_heap_timer_queue test passed");
    end else begin
      $display("min_heap_timer_queue test failed");
    end
    $finish;
  end

endmodule
